// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ahbc_pkg.sv =====
// ----------------------------------------------------------------------------
// ahbc_pkg
// Types, register indexes and helpers shared by the affine Hill cipher unit.
// ----------------------------------------------------------------------------
package ahbc_pkg;

    // Fixed widths of fields and configuration registers.
    localparam int MOD_W     = 8;
    localparam int FIELD_W   = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_COUNT = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS  = 3'd0,
        CFG_KEY_ROW0 = 3'd1,
        CFG_KEY_ROW1 = 3'd2,
        CFG_KEY_ROW2 = 3'd3,
        CFG_INV_ROW0 = 3'd4,
        CFG_INV_ROW1 = 3'd5,
        CFG_INV_ROW2 = 3'd6,
        CFG_SHIFT    = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic [MOD_W-1:0] RST_MODULUS = 8'd7;
    localparam logic [CFG_W-1:0] RST_ROW0    = 24'h000001;
    localparam logic [CFG_W-1:0] RST_ROW1    = 24'h000100;
    localparam logic [CFG_W-1:0] RST_ROW2    = 24'h010000;
    localparam logic [CFG_W-1:0] RST_SHIFT   = 24'h000000;

    // Operation selector values.
    localparam logic FUNC_DECRYPT = 1'b1;

    // One input request.
    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] sym0;
        logic [FIELD_W-1:0] sym1;
        logic [FIELD_W-1:0] sym2;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [FIELD_W-1:0] res0;
        logic [FIELD_W-1:0] res1;
        logic [FIELD_W-1:0] res2;
    } t_out_item;

    // Control carried along the cell chains.
    typedef struct packed {
        logic valid;
        logic reduce;
    } t_cell_ctl;

    // Byte j of a packed row of three entries.
    function automatic logic [7:0] byte_of(input logic [CFG_W-1:0] row, input int unsigned j);
        return row[8*j +: 8];
    endfunction

endpackage

// ===== src/ahbc_in_if.sv =====
// ----------------------------------------------------------------------------
// ahbc_in_if
// Valid/ready channel that carries one cipher request.
// ----------------------------------------------------------------------------
interface ahbc_in_if;
    import ahbc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ahbc_out_if.sv =====
// ----------------------------------------------------------------------------
// ahbc_out_if
// Valid/ready channel that carries one cipher result.
// ----------------------------------------------------------------------------
interface ahbc_out_if;
    import ahbc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/ahbc_mod_cell.sv =====
// ----------------------------------------------------------------------------
// ahbc_mod_cell
// One restoring-reduction step: when reduce is set, each lane loses N << SHIFT
// when it is not smaller, then the request moves to the next cell.
// ----------------------------------------------------------------------------
module ahbc_mod_cell #(
    parameter int LANES = 3,
    parameter int W     = 8,
    parameter int SHIFT = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ahbc_pkg::t_cell_ctl           i_ctl,
    output logic                          o_ready,
    input  logic [LANES-1:0][W-1:0]       i_lane,
    input  logic [ahbc_pkg::MOD_W-1:0]    i_n,
    output ahbc_pkg::t_cell_ctl           o_ctl,
    input  logic                          i_ready,
    output logic [LANES-1:0][W-1:0]       o_lane
);
    import ahbc_pkg::*;

    localparam int CW = W + MOD_W;

    t_cell_ctl               r_ctl;
    logic [LANES-1:0][W-1:0] r_lane;
    logic [LANES-1:0][W-1:0] n_lane;
    logic [CW-1:0]           step;

    // The stage takes a request when it is empty or its content moves on.
    assign o_ready = !r_ctl.valid || i_ready;

    // Conditional subtract of the shifted modulus on every lane.
    assign step = {{W{1'b0}}, i_n} << SHIFT;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (i_ctl.reduce && ({{MOD_W{1'b0}}, i_lane[k]} >= step)) begin
                n_lane[k] = W'({{MOD_W{1'b0}}, i_lane[k]} - step);
            end else begin
                n_lane[k] = i_lane[k];
            end
        end
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    // Lane data.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_lane <= n_lane;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_lane = r_lane;
endmodule

// ===== src/ahbc_mac.sv =====
// ----------------------------------------------------------------------------
// ahbc_mac
// Three-stage matrix-vector multiply: operand selection, products, row sums.
// ----------------------------------------------------------------------------
module ahbc_mac #(
    parameter int BLOCK_LEN = 3,
    parameter int SYM_BITS  = 8
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  ahbc_pkg::t_cell_ctl                                i_ctl,
    output logic                                               o_ready,
    input  logic [2*BLOCK_LEN-1:0][SYM_BITS-1:0]               i_lane,
    input  logic [ahbc_pkg::MOD_W-1:0]                         i_n,
    input  logic [ahbc_pkg::ROW_COUNT-1:0][ahbc_pkg::CFG_W-1:0] i_key,
    input  logic [ahbc_pkg::ROW_COUNT-1:0][ahbc_pkg::CFG_W-1:0] i_inv,
    input  logic [ahbc_pkg::CFG_W-1:0]                         i_shift,
    output ahbc_pkg::t_cell_ctl                                o_ctl,
    input  logic                                               i_ready,
    output logic [BLOCK_LEN-1:0][SYM_BITS+ahbc_pkg::MOD_W+$clog2(BLOCK_LEN+1)-1:0] o_acc
);
    import ahbc_pkg::*;

    localparam int L     = BLOCK_LEN;
    localparam int S     = SYM_BITS;
    localparam int PW    = S + MOD_W;
    localparam int ACC_W = PW + $clog2(L + 1);

    // Stage 1 registers: vector, coefficients, addend.
    logic                         r1_valid;
    logic [L-1:0][MOD_W-1:0]      r1_v;
    logic [L-1:0][L-1:0][S-1:0]   r1_c;
    logic [L-1:0][S-1:0]          r1_a;
    logic [L-1:0][MOD_W-1:0]      n1_v;
    logic [L-1:0][L-1:0][S-1:0]   n1_c;
    logic [L-1:0][S-1:0]          n1_a;

    // Stage 2 registers: products.
    logic                         r2_valid;
    logic [L-1:0][L-1:0][PW-1:0]  r2_p;
    logic [L-1:0][S-1:0]          r2_a;

    // Stage 3 registers: row sums.
    logic                         r3_valid;
    logic [L-1:0][ACC_W-1:0]      r3_acc;
    logic [L-1:0][ACC_W-1:0]      n3_acc;

    logic rdy2;
    logic rdy3;
    logic dec;

    assign dec     = (i_ctl.reduce == FUNC_DECRYPT);
    assign rdy3    = !r3_valid || i_ready;
    assign rdy2    = !r2_valid || rdy3;
    assign o_ready = !r1_valid || rdy2;

    // Decrypt takes (sym - h) mod N from reduced operands; encrypt takes sym.
    always_comb begin
        logic [MOD_W:0] t;
        logic [MOD_W:0] adj;
        logic [7:0]     kb;
        logic [7:0]     ib;
        logic [7:0]     hb;
        for (int j = 0; j < L; j++) begin
            t   = (MOD_W+1)'(i_lane[j]) + (MOD_W+1)'(i_n) - (MOD_W+1)'(i_lane[L+j]);
            adj = (t >= (MOD_W+1)'(i_n)) ? (t - (MOD_W+1)'(i_n)) : t;
            n1_v[j] = dec ? MOD_W'(adj) : MOD_W'(i_lane[j]);
        end
        for (int i = 0; i < L; i++) begin
            hb      = byte_of(i_shift, i);
            n1_a[i] = dec ? '0 : hb[S-1:0];
            for (int j = 0; j < L; j++) begin
                kb         = byte_of(i_key[i], j);
                ib         = byte_of(i_inv[i], j);
                n1_c[i][j] = dec ? ib[S-1:0] : kb[S-1:0];
            end
        end
    end

    // Row sums of the registered products plus the addend.
    always_comb begin
        for (int i = 0; i < L; i++) begin
            n3_acc[i] = ACC_W'(r2_a[i]);
            for (int j = 0; j < L; j++) begin
                n3_acc[i] = n3_acc[i] + ACC_W'(r2_p[i][j]);
            end
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_valid <= i_ctl.valid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
        end
    end

    // Stage data.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r1_v <= n1_v;
            r1_c <= n1_c;
            r1_a <= n1_a;
        end
        if (rdy2) begin
            for (int i = 0; i < L; i++) begin
                for (int j = 0; j < L; j++) begin
                    r2_p[i][j] <= PW'(r1_c[i][j]) * PW'(r1_v[j]);
                end
            end
            r2_a <= r1_a;
        end
        if (rdy3) begin
            r3_acc <= n3_acc;
        end
    end

    // The reduction chain after this stage always reduces.
    assign o_ctl = '{valid: r3_valid, reduce: 1'b1};
    assign o_acc = r3_acc;
endmodule

// ===== src/affine_hill_block_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// affine_hill_block_cipher_unit
// Affine Hill block cipher over a configurable modulus, built as cell chains.
// ----------------------------------------------------------------------------
// Usage:
//   i_blk carries one request: func (0 encrypt, 1 decrypt) and three symbols.
//   o_res returns one result per request, in order: three residues mod N.
//   Both channels move a request when valid and ready are high at a clock edge.
//   Configuration (modulus, key rows, inverse rows, shift) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
// Timing:
//   A request passes the first chain of reduction cells, the three multiply
//   stages, then the second chain on row sums of ACC_W = SYM_BITS + 8 +
//   clog2(BLOCK_LEN + 1) bits, one subtract step per cell. One request enters
//   per cycle while i_blk.ready is high.
// Reset and stall:
//   Reset empties every stage and loads the register defaults. When o_res is
//   not ready, requests pile up stage by stage and i_blk.ready falls only once
//   the chain is full; a held result stays stable on o_res.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_hill_block_cipher_unit #(
    parameter int BLOCK_LEN = 3,
    parameter int SYM_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ahbc_in_if.sink                           i_blk,
    ahbc_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [ahbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ahbc_pkg::CFG_W-1:0]        i_cfg_data
);
    import ahbc_pkg::*;

    localparam int L     = BLOCK_LEN;
    localparam int S     = SYM_BITS;
    localparam int ACC_W = S + MOD_W + $clog2(L + 1);

    // Configuration registers.
    logic [MOD_W-1:0]                r_mod;
    logic [ROW_COUNT-1:0][CFG_W-1:0] r_key;
    logic [ROW_COUNT-1:0][CFG_W-1:0] r_inv;
    logic [CFG_W-1:0]                r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= RST_MODULUS;
            r_key[0] <= RST_ROW0;
            r_key[1] <= RST_ROW1;
            r_key[2] <= RST_ROW2;
            r_inv[0] <= RST_ROW0;
            r_inv[1] <= RST_ROW1;
            r_inv[2] <= RST_ROW2;
            r_shift  <= RST_SHIFT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MODULUS:  r_mod    <= i_cfg_data[MOD_W-1:0];
                CFG_KEY_ROW0: r_key[0] <= i_cfg_data;
                CFG_KEY_ROW1: r_key[1] <= i_cfg_data;
                CFG_KEY_ROW2: r_key[2] <= i_cfg_data;
                CFG_INV_ROW0: r_inv[0] <= i_cfg_data;
                CFG_INV_ROW1: r_inv[1] <= i_cfg_data;
                CFG_INV_ROW2: r_inv[2] <= i_cfg_data;
                CFG_SHIFT:    r_shift  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // First chain: reduces symbols and shift entries mod N for decryption.
    t_cell_ctl                  pre_ctl  [S+1];
    logic [2*L-1:0][S-1:0]      pre_lane [S+1];
    logic                       pre_rdy  [S+1];
    logic [2:0][FIELD_W-1:0]    in_sym;

    assign in_sym     = {i_blk.data.sym2, i_blk.data.sym1, i_blk.data.sym0};
    assign pre_ctl[0] = '{valid: i_blk.valid, reduce: i_blk.data.func};
    assign i_blk.ready = pre_rdy[0];

    always_comb begin
        logic [7:0] hb;
        for (int j = 0; j < L; j++) begin
            hb              = byte_of(r_shift, j);
            pre_lane[0][j]   = in_sym[j][S-1:0];
            pre_lane[0][L+j] = hb[S-1:0];
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_pre
        ahbc_mod_cell #(
            .LANES (2*L),
            .W     (S),
            .SHIFT (S-1-k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (pre_ctl[k]),
            .o_ready (pre_rdy[k]),
            .i_lane  (pre_lane[k]),
            .i_n     (r_mod),
            .o_ctl   (pre_ctl[k+1]),
            .i_ready (pre_rdy[k+1]),
            .o_lane  (pre_lane[k+1])
        );
    end

    // Matrix-vector multiply with the affine shift.
    t_cell_ctl                  mod_ctl  [ACC_W+1];
    logic [L-1:0][ACC_W-1:0]    mod_lane [ACC_W+1];
    logic                       mod_rdy  [ACC_W+1];

    ahbc_mac #(
        .BLOCK_LEN (BLOCK_LEN),
        .SYM_BITS  (SYM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pre_ctl[S]),
        .o_ready (pre_rdy[S]),
        .i_lane  (pre_lane[S]),
        .i_n     (r_mod),
        .i_key   (r_key),
        .i_inv   (r_inv),
        .i_shift (r_shift),
        .o_ctl   (mod_ctl[0]),
        .i_ready (mod_rdy[0]),
        .o_acc   (mod_lane[0])
    );

    // Second chain: reduces the row sums mod N.
    for (genvar k = 0; k < ACC_W; k++) begin : g_mod
        ahbc_mod_cell #(
            .LANES (L),
            .W     (ACC_W),
            .SHIFT (ACC_W-1-k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (mod_ctl[k]),
            .o_ready (mod_rdy[k]),
            .i_lane  (mod_lane[k]),
            .i_n     (r_mod),
            .o_ctl   (mod_ctl[k+1]),
            .i_ready (mod_rdy[k+1]),
            .o_lane  (mod_lane[k+1])
        );
    end

    // Result: the last cell is the output register; a modulus below two gives zeros.
    logic                        mod_ok;
    logic [2:0][FIELD_W-1:0]     res;

    assign mod_ok = (r_mod >= MOD_W'(2));

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            res[j] = '0;
        end
        for (int j = 0; j < L; j++) begin
            res[j] = mod_ok ? FIELD_W'(mod_lane[ACC_W][j]) : '0;
        end
    end

    assign o_res.valid     = mod_ctl[ACC_W].valid;
    assign o_res.data.res0 = res[0];
    assign o_res.data.res1 = res[1];
    assign o_res.data.res2 = res[2];
    assign mod_rdy[ACC_W]  = o_res.ready;

    // Checks on the reduction chains.
    `ASSERT_IMPLY(a_res0_residue, o_res.valid && mod_ok, o_res.data.res0 < r_mod, "res0 not reduced")
    `ASSERT_IMPLY(a_res1_residue, o_res.valid && mod_ok, o_res.data.res1 < r_mod, "res1 not reduced")
    `ASSERT_IMPLY(a_short_block, o_res.valid && (L < 3), o_res.data.res2 == '0, "res2 set in short block")
    `ASSERT_NEXT(a_accept_enters, i_blk.valid && i_blk.ready, pre_ctl[1].valid, "request lost at entry")
endmodule
